/* rtl/jcl_pkg.sv */
// Types and constants for the JSON character lexer.
// Used by json_char_lexer_top; depends on nothing else.
`default_nettype none

package jcl_pkg;

    // Lexer modes, one-hot
    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_STR  = 5'b00010,
        MODE_NUM  = 5'b00100,
        MODE_ID   = 5'b01000,
        MODE_ERR  = 5'b10000
    } mode_t;

    // Event kinds
    localparam logic [1:0] EV_APPEND = 2'd0;
    localparam logic [1:0] EV_DONE   = 2'd1;
    localparam logic [1:0] EV_ERROR  = 2'd2;

    // Token kinds
    localparam logic [3:0] TOK_NONE   = 4'd0;
    localparam logic [3:0] TOK_STRING = 4'd1;
    localparam logic [3:0] TOK_NUMBER = 4'd2;
    localparam logic [3:0] TOK_IDENT  = 4'd3;
    localparam logic [3:0] TOK_COMMA  = 4'd4;
    localparam logic [3:0] TOK_COLON  = 4'd5;
    localparam logic [3:0] TOK_LBRACE = 4'd6;
    localparam logic [3:0] TOK_RBRACE = 4'd7;
    localparam logic [3:0] TOK_LBRACK = 4'd8;
    localparam logic [3:0] TOK_RBRACK = 4'd9;

    // Error codes
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_BAD_START  = 2'd1;
    localparam logic [1:0] ERR_BAD_NUMBER = 2'd2;
    localparam logic [1:0] ERR_BAD_IDENT  = 2'd3;

    // Characters
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_FF     = 8'h0C;

    // Width of the position fields in a result
    localparam int unsigned POS_W = 16;

    // One result beat
    typedef struct packed {
        logic [1:0]       event_kind;
        logic [3:0]       token_kind;
        logic [7:0]       byte_value;
        logic [POS_W-1:0] line_number;
        logic [POS_W-1:0] column_number;
        logic [1:0]       error_code;
        logic             last_of_run;
    } res_t;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    function automatic res_t mk_res(
        input logic [1:0] ev,
        input logic [3:0] tok,
        input logic [7:0] byt,
        input logic [1:0] err
    );
        res_t r;
        r               = '0;
        r.event_kind    = ev;
        r.token_kind    = tok;
        r.byte_value    = byt;
        r.error_code    = err;
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/json_char_lexer_top.sv */
// JSON character lexer on jcl_pkg: one text byte per beat in, event beats out.
// Events are registered in the result queue before they are offered on the master side.
// Throughput: one byte per cycle while m_tready stays high and each byte yields at most
// one event; a byte that yields two events (flush plus punctuation) adds a beat that
// the single-beat output port must drain from a four-entry result queue.
// Reset: asynchronous, active low; mode idle, line 1, column 1, queue empty.
`default_nettype none

module json_char_lexer_top #(
    parameter int unsigned LINE_BITS   = 16,
    parameter int unsigned COLUMN_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] text_byte
    input  wire logic        s_tlast,   // final_byte
    // event stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [47:0]      m_tdata,   // [3:0] token_kind, [11:4] byte_value,
                                        // [27:12] line_number, [43:28] column_number,
                                        // [45:44] error_code, [47:46] zero
    output logic [1:0]       m_tuser,   // [1:0] event_kind
    output logic             m_tlast    // last_of_run
);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
    localparam logic [QCNT_W-1:0] QREADY_MAX = QCNT_W'(QDEPTH - 2);

    // lexer state
    jcl_pkg::mode_t          mode_reg, mode_next;
    logic                    dq_reg, dq_next;
    logic                    dot_reg, dot_next;
    logic [LINE_BITS-1:0]    line_reg, line_next;
    logic [COLUMN_BITS-1:0]  col_reg, col_next;

    // result queue
    jcl_pkg::res_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QCNT_W-1:0]       cnt_reg, cnt_next;

    logic                    accept, pop;
    logic [7:0]              b;
    logic                    fin;

    // per-byte events: an optional flush of the pending token and an optional main event
    logic                    flush_vld, main_vld;
    jcl_pkg::res_t           flush_res, main_res, res_a, res_b;
    logic [1:0]              n_res;
    logic [3:0]              pend_kind;
    logic                    pending;
    logic                    close_quote;
    logic [31:0]             line_wide, col_wide;
    jcl_pkg::res_t           head;

    assign b        = s_tdata;
    assign fin      = s_tlast;
    assign s_tready = (cnt_reg <= QREADY_MAX);
    assign accept   = s_tvalid && s_tready;
    assign pop      = m_tvalid && m_tready;

    assign pending     = (mode_reg == jcl_pkg::MODE_NUM) || (mode_reg == jcl_pkg::MODE_ID);
    assign pend_kind   = (mode_reg == jcl_pkg::MODE_NUM) ? jcl_pkg::TOK_NUMBER
                                                         : jcl_pkg::TOK_IDENT;
    assign close_quote = dq_reg ? (b == jcl_pkg::CH_DQUOTE) : (b == jcl_pkg::CH_SQUOTE);

    always_comb
    begin
        mode_next = mode_reg;
        dq_next   = dq_reg;
        dot_next  = dot_reg;
        line_next = line_reg;
        col_next  = col_reg;
        flush_vld = 1'b0;
        main_vld  = 1'b0;
        flush_res = jcl_pkg::mk_res(jcl_pkg::EV_DONE, pend_kind, 8'h00, jcl_pkg::ERR_NONE);
        main_res  = jcl_pkg::mk_res(jcl_pkg::EV_APPEND, jcl_pkg::TOK_NONE, b,
                                    jcl_pkg::ERR_NONE);

        if (mode_reg != jcl_pkg::MODE_ERR)
        begin
            col_next = (&col_reg) ? col_reg : col_reg + 1'b1;
            if (b == jcl_pkg::CH_LF)
            begin
                line_next = (&line_reg) ? line_reg : line_reg + 1'b1;
                col_next  = COLUMN_BITS'(1);
            end
        end

        case (mode_reg)
            jcl_pkg::MODE_ERR:
            begin
                // ignore everything until the final byte
            end
            jcl_pkg::MODE_STR:
            begin
                main_vld = 1'b1;
                if (close_quote)
                begin
                    main_res  = jcl_pkg::mk_res(jcl_pkg::EV_DONE, jcl_pkg::TOK_STRING,
                                                8'h00, jcl_pkg::ERR_NONE);
                    mode_next = jcl_pkg::MODE_IDLE;
                end
                else
                begin
                    main_res = jcl_pkg::mk_res(jcl_pkg::EV_APPEND, jcl_pkg::TOK_STRING,
                                               b, jcl_pkg::ERR_NONE);
                end
            end
            default:
            begin
                case (b)
                    jcl_pkg::CH_BSLASH, jcl_pkg::CH_SQUOTE, jcl_pkg::CH_DQUOTE:
                    begin
                        flush_vld = pending;
                        mode_next = jcl_pkg::MODE_STR;
                        dq_next   = (b == jcl_pkg::CH_DQUOTE);
                    end
                    jcl_pkg::CH_COMMA, jcl_pkg::CH_COLON, jcl_pkg::CH_LBRACE,
                    jcl_pkg::CH_RBRACE, jcl_pkg::CH_LBRACK, jcl_pkg::CH_RBRACK:
                    begin
                        flush_vld = pending;
                        main_vld  = 1'b1;
                        mode_next = jcl_pkg::MODE_IDLE;
                        main_res  = jcl_pkg::mk_res(jcl_pkg::EV_DONE, jcl_pkg::TOK_NONE, b,
                                                    jcl_pkg::ERR_NONE);
                        case (b)
                            jcl_pkg::CH_COMMA:  main_res.token_kind = jcl_pkg::TOK_COMMA;
                            jcl_pkg::CH_COLON:  main_res.token_kind = jcl_pkg::TOK_COLON;
                            jcl_pkg::CH_LBRACE: main_res.token_kind = jcl_pkg::TOK_LBRACE;
                            jcl_pkg::CH_RBRACE: main_res.token_kind = jcl_pkg::TOK_RBRACE;
                            jcl_pkg::CH_LBRACK: main_res.token_kind = jcl_pkg::TOK_LBRACK;
                            default:            main_res.token_kind = jcl_pkg::TOK_RBRACK;
                        endcase
                    end
                    jcl_pkg::CH_SPACE, jcl_pkg::CH_TAB, jcl_pkg::CH_LF,
                    jcl_pkg::CH_CR, jcl_pkg::CH_FF:
                    begin
                        flush_vld = pending;
                        mode_next = jcl_pkg::MODE_IDLE;
                    end
                    default:
                    begin
                        main_vld = 1'b1;
                        if (mode_reg == jcl_pkg::MODE_NUM)
                        begin
                            if ((!jcl_pkg::is_digit(b) && (b != jcl_pkg::CH_DOT)) ||
                                ((b == jcl_pkg::CH_DOT) && dot_reg))
                            begin
                                main_res  = jcl_pkg::mk_res(jcl_pkg::EV_ERROR,
                                                            jcl_pkg::TOK_NONE, b,
                                                            jcl_pkg::ERR_BAD_NUMBER);
                                mode_next = jcl_pkg::MODE_ERR;
                            end
                            else
                            begin
                                main_res.token_kind = jcl_pkg::TOK_NUMBER;
                                if (b == jcl_pkg::CH_DOT)
                                begin
                                    dot_next = 1'b1;
                                end
                            end
                        end
                        else if (mode_reg == jcl_pkg::MODE_ID)
                        begin
                            if (!jcl_pkg::is_alpha(b) && !jcl_pkg::is_digit(b) &&
                                (b != jcl_pkg::CH_UNDER))
                            begin
                                main_res  = jcl_pkg::mk_res(jcl_pkg::EV_ERROR,
                                                            jcl_pkg::TOK_NONE, b,
                                                            jcl_pkg::ERR_BAD_IDENT);
                                mode_next = jcl_pkg::MODE_ERR;
                            end
                            else
                            begin
                                main_res.token_kind = jcl_pkg::TOK_IDENT;
                            end
                        end
                        else
                        begin
                            // idle: the byte must open a number or an identifier
                            if (jcl_pkg::is_digit(b) || (b == jcl_pkg::CH_MINUS))
                            begin
                                mode_next           = jcl_pkg::MODE_NUM;
                                dot_next            = 1'b0;
                                main_res.token_kind = jcl_pkg::TOK_NUMBER;
                            end
                            else if (jcl_pkg::is_alpha(b) || (b == jcl_pkg::CH_UNDER))
                            begin
                                mode_next           = jcl_pkg::MODE_ID;
                                main_res.token_kind = jcl_pkg::TOK_IDENT;
                            end
                            else
                            begin
                                main_res  = jcl_pkg::mk_res(jcl_pkg::EV_ERROR,
                                                            jcl_pkg::TOK_NONE, b,
                                                            jcl_pkg::ERR_BAD_START);
                                mode_next = jcl_pkg::MODE_ERR;
                            end
                        end
                    end
                endcase
            end
        endcase

        // the final byte returns the lexer state to reset values
        if (fin)
        begin
            mode_next = jcl_pkg::MODE_IDLE;
            dq_next   = 1'b0;
            dot_next  = 1'b0;
            line_next = LINE_BITS'(1);
            col_next  = COLUMN_BITS'(1);
        end
    end

    // Position fields carry the low bits of the updated counters.
    assign line_wide = 32'(mode_reg == jcl_pkg::MODE_ERR ? line_reg :
                           ((b == jcl_pkg::CH_LF) ? ((&line_reg) ? line_reg
                                                                 : line_reg + 1'b1)
                                                  : line_reg));
    assign col_wide  = 32'(mode_reg == jcl_pkg::MODE_ERR ? col_reg :
                           ((b == jcl_pkg::CH_LF) ? COLUMN_BITS'(1)
                                                  : ((&col_reg) ? col_reg
                                                                : col_reg + 1'b1)));

    always_comb
    begin
        res_a = flush_vld ? flush_res : main_res;
        res_b = main_res;
        res_a.line_number   = line_wide[jcl_pkg::POS_W-1:0];
        res_a.column_number = col_wide[jcl_pkg::POS_W-1:0];
        res_b.line_number   = line_wide[jcl_pkg::POS_W-1:0];
        res_b.column_number = col_wide[jcl_pkg::POS_W-1:0];
        // mark the last beat of this byte
        res_a.last_of_run   = !(flush_vld && main_vld);
        res_b.last_of_run   = 1'b1;
        n_res = {1'b0, flush_vld} + {1'b0, main_vld};
    end

    always_comb
    begin
        rd_ptr_next = rd_ptr_reg;
        wr_ptr_next = wr_ptr_reg;
        cnt_next    = cnt_reg;
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (accept)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(n_res);
        end
        cnt_next = cnt_reg + (accept ? QCNT_W'(n_res) : '0) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= jcl_pkg::MODE_IDLE;
            dq_reg     <= 1'b0;
            dot_reg    <= 1'b0;
            line_reg   <= LINE_BITS'(1);
            col_reg    <= COLUMN_BITS'(1);
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg <= mode_next;
                dq_reg   <= dq_next;
                dot_reg  <= dot_next;
                line_reg <= line_next;
                col_reg  <= col_next;
            end
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // queue payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept && (n_res != 2'd0))
        begin
            q_reg[wr_ptr_reg] <= res_a;
        end
        if (accept && (n_res == 2'd2))
        begin
            q_reg[wr_ptr_reg + 1'b1] <= res_b;
        end
    end

    assign head     = q_reg[rd_ptr_reg];
    assign m_tvalid = (cnt_reg != '0);
    assign m_tdata  = {2'b00, head.error_code, head.column_number, head.line_number,
                       head.byte_value, head.token_kind};
    assign m_tuser  = head.event_kind;
    assign m_tlast  = head.last_of_run;

    // never hold more beats than the queue has entries
    a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= QCNT_W'(QDEPTH))
        else $error("result queue overflow");

    // the final byte restores the reset position and mode
    a_final_reset: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && fin) |=> (mode_reg == jcl_pkg::MODE_IDLE) &&
                            (line_reg == LINE_BITS'(1)) && (col_reg == COLUMN_BITS'(1)))
        else $error("state not restored after final byte");

    // an error-mode byte produces no beat
    a_err_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (mode_reg == jcl_pkg::MODE_ERR) && !pop) |=> $stable(cnt_reg))
        else $error("beat produced while in error mode");

    // counters start at one and never wrap to zero
    a_pos_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (line_reg != '0) && (col_reg != '0))
        else $error("position counter reached zero");

endmodule

`default_nettype wire
